FILE: design/wcfa_pkg.sv
// Shared types and constants for the wall contact force accumulator.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package wcfa_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int COEF_W     = 31;
  localparam int POS_W      = 32;
  localparam int RADIUS_W   = 31;
  localparam int VEL_W      = 32;
  localparam int OUT_W      = 32;
  localparam int TOT_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Gap to a wall spans about three times the 32-bit range, so 35 signed bits
  // hold it exactly and 34 bits hold its magnitude.
  localparam int GAP_W    = 35;
  localparam int MAG_W    = 34;
  localparam int MAG_LO_W = 32;

  localparam int NWALL       = 4;
  localparam int WALL_LEFT   = 0;
  localparam int WALL_RIGHT  = 1;
  localparam int WALL_UPPER  = 2;
  localparam int WALL_LOWER  = 3;

  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;
  localparam int BACK_STAGES = 4;

  localparam logic [COEF_W-1:0] STIFF_RESET = COEF_W'(65536);

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
  localparam logic [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFFNESS = 3'd0,
    REG_DAMPING   = 3'd1,
    REG_LEFT_POS  = 3'd2,
    REG_RIGHT_POS = 3'd3,
    REG_UPPER_POS = 3'd4,
    REG_LOWER_POS = 3'd5
  } cfg_reg_t;

  // One classified grain, handed from the front to the back through the queue.
  typedef struct packed {
    logic [NWALL-1:0]            contact;
    logic [NWALL-1:0][MAG_W-1:0] gap_mag;
    logic [NWALL-1:0]            vel_neg;
    logic [NWALL-1:0][VEL_W-1:0] vel_mag;
    logic                        last;
  } item_t;

endpackage

FILE: design/wall_contact_force_accumulator_top.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    grain position, radius, velocity, final mark
// out_      output     out_valid/out_ready  force increments, pressure, wall totals, pass_done
// cfg_      input      cfg_we (no wait)     register index and write data
//
// One grain per cycle sustained while the output does not stall; a grain moves from the front
// register through the queue and the multiply, scale, per-wall force and sum-and-clamp stages.
// The only loop is the four wall-sum additions, one add and clamp in the last stage.
// Synchronous active-low reset clears the sums and all valid flags and loads register defaults.
// A stall at the output backs up through the pipeline and the two-entry queue into the front.
`timescale 1ns / 1ps

module wall_contact_force_accumulator_top import wcfa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic [RADIUS_W-1:0]     in_radius,
  input  logic signed [VEL_W-1:0] in_vel_x,
  input  logic signed [VEL_W-1:0] in_vel_y,
  input  logic                    in_final_grain,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_force_x_add,
  output logic signed [OUT_W-1:0] out_force_y_add,
  output logic signed [OUT_W-1:0] out_pressure_add,
  output logic signed [TOT_W-1:0] out_upper_total,
  output logic signed [TOT_W-1:0] out_lower_total,
  output logic signed [TOT_W-1:0] out_left_total,
  output logic signed [TOT_W-1:0] out_right_total,
  output logic                    out_pass_done,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  logic [COEF_W-1:0]       stiffness_r, damping_r;
  logic signed [POS_W-1:0] left_pos_r, right_pos_r, upper_pos_r, lower_pos_r;

  logic  fq_valid, fq_ready, qb_valid, qb_ready;
  item_t fq_item, qb_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r <= STIFF_RESET;
      damping_r   <= '0;
      left_pos_r  <= '0;
      right_pos_r <= '0;
      upper_pos_r <= '0;
      lower_pos_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STIFFNESS: stiffness_r <= cfg_wdata[COEF_W-1:0];
        REG_DAMPING:   damping_r   <= cfg_wdata[COEF_W-1:0];
        REG_LEFT_POS:  left_pos_r  <= cfg_wdata[POS_W-1:0];
        REG_RIGHT_POS: right_pos_r <= cfg_wdata[POS_W-1:0];
        REG_UPPER_POS: upper_pos_r <= cfg_wdata[POS_W-1:0];
        REG_LOWER_POS: lower_pos_r <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  wcfa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_radius      (in_radius),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .in_final_grain (in_final_grain),
    .left_pos       (left_pos_r),
    .right_pos      (right_pos_r),
    .upper_pos      (upper_pos_r),
    .lower_pos      (lower_pos_r),
    .q_valid        (fq_valid),
    .q_ready        (fq_ready),
    .q_item         (fq_item)
  );

  wcfa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  wcfa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (qb_valid),
    .q_ready          (qb_ready),
    .q_item           (qb_item),
    .stiffness        (stiffness_r),
    .damping          (damping_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_force_x_add  (out_force_x_add),
    .out_force_y_add  (out_force_y_add),
    .out_pressure_add (out_pressure_add),
    .out_upper_total  (out_upper_total),
    .out_lower_total  (out_lower_total),
    .out_left_total   (out_left_total),
    .out_right_total  (out_right_total),
    .out_pass_done    (out_pass_done)
  );

endmodule

FILE: design/wcfa_front.sv
// Front end: accepts grains, forms the four wall gaps and normal velocities.
// Depends on wcfa_pkg.
`timescale 1ns / 1ps

module wcfa_front import wcfa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic [RADIUS_W-1:0]     in_radius,
  input  logic signed [VEL_W-1:0] in_vel_x,
  input  logic signed [VEL_W-1:0] in_vel_y,
  input  logic                    in_final_grain,
  input  logic signed [POS_W-1:0] left_pos,
  input  logic signed [POS_W-1:0] right_pos,
  input  logic signed [POS_W-1:0] upper_pos,
  input  logic signed [POS_W-1:0] lower_pos,
  output logic                    q_valid,
  input  logic                    q_ready,
  output item_t                   q_item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  logic signed [GAP_W-1:0] px_e, py_e, r_e;
  logic signed [GAP_W-1:0] dn [NWALL];
  logic signed [GAP_W-1:0] dn_neg [NWALL];
  logic [VEL_W-1:0]        vx_mag, vy_mag;

  assign in_ready = !valid_r || q_ready;
  assign q_valid  = valid_r;
  assign q_item   = item_r;

  assign px_e = GAP_W'(in_pos_x);
  assign py_e = GAP_W'(in_pos_y);
  assign r_e  = $signed(GAP_W'(in_radius));

  always_comb begin
    dn[WALL_LEFT]  = px_e - r_e - GAP_W'(left_pos);
    dn[WALL_RIGHT] = GAP_W'(right_pos) - (px_e + r_e);
    dn[WALL_UPPER] = GAP_W'(upper_pos) - (py_e + r_e);
    dn[WALL_LOWER] = py_e - r_e - GAP_W'(lower_pos);
    for (int i = 0; i < NWALL; i++) begin
      dn_neg[i] = -dn[i];
    end
  end

  // A two's complement negate of the most negative value still gives its magnitude.
  assign vx_mag = in_vel_x[VEL_W-1] ? VEL_W'(-in_vel_x) : in_vel_x;
  assign vy_mag = in_vel_y[VEL_W-1] ? VEL_W'(-in_vel_y) : in_vel_y;

  always_comb begin
    item_nxt = item_r;
    if (in_valid && in_ready) begin
      for (int i = 0; i < NWALL; i++) begin
        item_nxt.contact[i] = dn[i][GAP_W-1];
        item_nxt.gap_mag[i] = dn_neg[i][MAG_W-1:0];
      end
      // Right and upper walls see the velocity with its sign flipped.
      item_nxt.vel_neg[WALL_LEFT]  = in_vel_x[VEL_W-1];
      item_nxt.vel_neg[WALL_RIGHT] = (in_vel_x != '0) && !in_vel_x[VEL_W-1];
      item_nxt.vel_neg[WALL_UPPER] = (in_vel_y != '0) && !in_vel_y[VEL_W-1];
      item_nxt.vel_neg[WALL_LOWER] = in_vel_y[VEL_W-1];
      item_nxt.vel_mag[WALL_LEFT]  = vx_mag;
      item_nxt.vel_mag[WALL_RIGHT] = vx_mag;
      item_nxt.vel_mag[WALL_UPPER] = vy_mag;
      item_nxt.vel_mag[WALL_LOWER] = vy_mag;
      item_nxt.last                = in_final_grain;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (q_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

FILE: design/wcfa_queue.sv
// Two-entry queue between the front end and the force pipeline.
// Depends on wcfa_pkg for the item type and depth.
`timescale 1ns / 1ps

module wcfa_queue import wcfa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;
  logic                push, pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: design/wcfa_back.sv
// Force pipeline: multiply, scale, combine per wall, then saturate and accumulate.
// Depends on wcfa_pkg; FRAC_BITS comes from the top level.
`timescale 1ns / 1ps

module wcfa_back import wcfa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  item_t                   q_item,
  input  logic [COEF_W-1:0]       stiffness,
  input  logic [COEF_W-1:0]       damping,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_force_x_add,
  output logic signed [OUT_W-1:0] out_force_y_add,
  output logic signed [OUT_W-1:0] out_pressure_add,
  output logic signed [TOT_W-1:0] out_upper_total,
  output logic signed [TOT_W-1:0] out_lower_total,
  output logic signed [TOT_W-1:0] out_left_total,
  output logic signed [TOT_W-1:0] out_right_total,
  output logic                    out_pass_done
);

  localparam int KLO_W = COEF_W + MAG_LO_W;
  localparam int KHI_W = COEF_W + MAG_W - MAG_LO_W;
  localparam int KD_W  = COEF_W + VEL_W;
  localparam int KS_W  = COEF_W + MAG_W - FRAC_BITS;
  localparam int KD2_W = KD_W - FRAC_BITS;
  localparam int FN_W  = KS_W + 1;
  localparam int FX_W  = FN_W + 1;
  localparam int P_W   = FN_W + 2;
  localparam int SUM_W = ((TOT_W > FN_W) ? TOT_W : FN_W) + 1;

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  // Stage 1: raw products.
  logic [KLO_W-1:0] klo_r [NWALL];
  logic [KHI_W-1:0] khi_r [NWALL];
  logic [KD_W-1:0]  kd_r  [NWALL];
  logic [NWALL-1:0] c1_r, n1_r;
  logic             l1_r;

  // Stage 2: products scaled back to the fixed-point grid.
  logic [KS_W-1:0]  ks_r  [NWALL];
  logic [KD2_W-1:0] kd2_r [NWALL];
  logic [NWALL-1:0] c2_r, n2_r;
  logic             l2_r;

  // Stage 3: per-wall normal force.
  logic signed [FN_W-1:0] fn_r [NWALL];
  logic                   l3_r;
  logic signed [FN_W-1:0] fn_nxt [NWALL];

  // Stage 4: results and running wall sums.
  logic signed [TOT_W-1:0] sum_r [NWALL];
  logic signed [TOT_W-1:0] tot_nxt [NWALL];
  logic signed [SUM_W-1:0] acc [NWALL];
  logic signed [FX_W-1:0]  fx_s, fy_s;
  logic signed [P_W-1:0]   p_s;
  logic [OUT_W-1:0]        fx_sat, fy_sat, p_sat;

  logic signed [OUT_W-1:0] fx_r, fy_r, p_r;
  logic signed [TOT_W-1:0] tot_r [NWALL];
  logic                    done_r;

  assign en4     = !v4_r || out_ready;
  assign en3     = !v3_r || en4;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign q_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= q_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && q_valid) begin
      for (int i = 0; i < NWALL; i++) begin
        klo_r[i] <= KLO_W'(q_item.gap_mag[i][MAG_LO_W-1:0]) * KLO_W'(stiffness);
        khi_r[i] <= KHI_W'(q_item.gap_mag[i][MAG_W-1:MAG_LO_W]) * KHI_W'(stiffness);
        kd_r[i]  <= KD_W'(q_item.vel_mag[i]) * KD_W'(damping);
      end
      c1_r <= q_item.contact;
      n1_r <= q_item.vel_neg;
      l1_r <= q_item.last;
    end
  end

  // The high product sits 32 bits up, so only the low product loses fraction bits.
  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      for (int i = 0; i < NWALL; i++) begin
        ks_r[i]  <= (KS_W'(khi_r[i]) << (MAG_LO_W - FRAC_BITS))
                    + KS_W'(klo_r[i][KLO_W-1:FRAC_BITS]);
        kd2_r[i] <= kd_r[i][KD_W-1:FRAC_BITS];
      end
      c2_r <= c1_r;
      n2_r <= n1_r;
      l2_r <= l1_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NWALL; i++) begin
      if (!c2_r[i]) begin
        fn_nxt[i] = '0;
      end else if (n2_r[i]) begin
        fn_nxt[i] = $signed(FN_W'(ks_r[i])) + $signed(FN_W'(kd2_r[i]));
      end else begin
        fn_nxt[i] = $signed(FN_W'(ks_r[i])) - $signed(FN_W'(kd2_r[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      for (int i = 0; i < NWALL; i++) begin
        fn_r[i] <= fn_nxt[i];
      end
      l3_r <= l2_r;
    end
  end

  always_comb begin
    fx_s = FX_W'(fn_r[WALL_LEFT]) - FX_W'(fn_r[WALL_RIGHT]);
    fy_s = FX_W'(fn_r[WALL_LOWER]) - FX_W'(fn_r[WALL_UPPER]);
    p_s  = P_W'(fn_r[WALL_LEFT]) + P_W'(fn_r[WALL_RIGHT])
         + P_W'(fn_r[WALL_UPPER]) + P_W'(fn_r[WALL_LOWER]);

    // A value fits when every bit above the target sign bit matches it.
    if ((&fx_s[FX_W-1:OUT_W-1]) || !(|fx_s[FX_W-1:OUT_W-1])) begin
      fx_sat = fx_s[OUT_W-1:0];
    end else begin
      fx_sat = fx_s[FX_W-1] ? OUT_MIN : OUT_MAX;
    end
    if ((&fy_s[FX_W-1:OUT_W-1]) || !(|fy_s[FX_W-1:OUT_W-1])) begin
      fy_sat = fy_s[OUT_W-1:0];
    end else begin
      fy_sat = fy_s[FX_W-1] ? OUT_MIN : OUT_MAX;
    end
    if ((&p_s[P_W-1:OUT_W-1]) || !(|p_s[P_W-1:OUT_W-1])) begin
      p_sat = p_s[OUT_W-1:0];
    end else begin
      p_sat = p_s[P_W-1] ? OUT_MIN : OUT_MAX;
    end

    for (int i = 0; i < NWALL; i++) begin
      acc[i] = SUM_W'(sum_r[i]) + SUM_W'(fn_r[i]);
      if ((&acc[i][SUM_W-1:TOT_W-1]) || !(|acc[i][SUM_W-1:TOT_W-1])) begin
        tot_nxt[i] = acc[i][TOT_W-1:0];
      end else begin
        tot_nxt[i] = acc[i][SUM_W-1] ? TOT_MIN : TOT_MAX;
      end
    end
  end

  // The sums restart from zero after the last grain of a pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NWALL; i++) begin
        sum_r[i] <= '0;
      end
    end else if (en4 && v3_r) begin
      for (int i = 0; i < NWALL; i++) begin
        sum_r[i] <= l3_r ? '0 : tot_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      fx_r   <= fx_sat;
      fy_r   <= fy_sat;
      p_r    <= p_sat;
      done_r <= l3_r;
      for (int i = 0; i < NWALL; i++) begin
        tot_r[i] <= tot_nxt[i];
      end
    end
  end

  assign out_valid        = v4_r;
  assign out_force_x_add  = fx_r;
  assign out_force_y_add  = fy_r;
  assign out_pressure_add = p_r;
  assign out_upper_total  = tot_r[WALL_UPPER];
  assign out_lower_total  = tot_r[WALL_LOWER];
  assign out_left_total   = tot_r[WALL_LEFT];
  assign out_right_total  = tot_r[WALL_RIGHT];
  assign out_pass_done    = done_r;

endmodule

FILE: design/wcfa_checker.sv
// Port-level checks for the wall contact force accumulator, bound to the top level.
// Depends on wcfa_pkg for widths and pipeline capacity.
`timescale 1ns / 1ps

module wcfa_checker import wcfa_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_force_x_add,
  input logic signed [TOT_W-1:0] out_left_total,
  input logic                    out_pass_done
);

  // Front register, queue entries and back stages.
  localparam int CAPACITY = 1 + Q_DEPTH + BACK_STAGES;
  localparam int CNT_W    = $clog2(CAPACITY + 2);

  logic [CNT_W-1:0] inflight_r, inflight_nxt;
  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_xfer && !out_xfer) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_force_x_add)
      && $stable(out_left_total) && $stable(out_pass_done))
    else $error("stalled result changed or dropped");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != '0)
    else $error("result shown with no grain outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(CAPACITY))
    else $error("more grains outstanding than the pipeline holds");

endmodule

bind wall_contact_force_accumulator_top wcfa_checker u_wcfa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_force_x_add (out_force_x_add),
  .out_left_total  (out_left_total),
  .out_pass_done   (out_pass_done)
);
